// File: hw/rtl/dedup_queue_with_promote_defines.svh
// Assertion macros for the deduplicating work queue.
`ifndef DEDUP_QUEUE_WITH_PROMOTE_DEFINES_SVH
`define DEDUP_QUEUE_WITH_PROMOTE_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define DQP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check a consequence in the cycle after its antecedent.
`define DQP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/dqp_pkg.sv
// Shared types and constants of the deduplicating work queue.
package dqp_pkg;

   localparam int QUEUE_DEPTH  = 128;
   localparam int NUM_CHUNKS   = 256;
   localparam int NUM_SECTIONS = 8;

   localparam int KIND_W    = 2;
   localparam int CHUNK_W   = 8;
   localparam int SECTION_W = 3;
   localparam int STATUS_W  = 3;
   localparam int DEPTH_W   = 8;
   localparam int PAIR_W    = CHUNK_W + SECTION_W;
   localparam int COUNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_TDATA_W = ((PAIR_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = STATUS_W + PAIR_W + DEPTH_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH    = 2'd0,
      KIND_PROMOTE = 2'd1,
      KIND_POP     = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_QUEUED   = 3'd0,
      ST_DUP      = 3'd1,
      ST_FULL     = 3'd2,
      ST_PROMOTED = 3'd3,
      ST_NOTQ     = 3'd4,
      ST_POPPED   = 3'd5,
      ST_EMPTY    = 3'd6
   } status_type;

   // Chunk sits in the low bits, matching the stream packing.
   typedef struct packed {
      logic [SECTION_W-1:0] section;
      logic [CHUNK_W-1:0]   chunk;
   } pair_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MATCH,
      S_APPLY,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic capture;
      logic match;
      logic apply;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
   } stat_type;

endpackage

// File: hw/rtl/dqp_ctrl.sv
// Sequencing state machine of the deduplicating work queue.
module dqp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dqp_pkg::stat_type stat,
   output dqp_pkg::cmd_type  cmd
);

   dqp_pkg::state_type state_ff;
   dqp_pkg::state_type state_in;

   // Hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dqp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Step through capture, compare, update and emit
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         dqp_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = dqp_pkg::S_MATCH;
            end
         end
         dqp_pkg::S_MATCH: begin
            cmd.match = 1'b1;
            state_in  = dqp_pkg::S_APPLY;
         end
         dqp_pkg::S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = dqp_pkg::S_EMIT;
         end
         dqp_pkg::S_EMIT: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = dqp_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = dqp_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/dqp_datapath.sv
// Cell chain, compare row, update logic and result register of the work queue.
module dqp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  dqp_pkg::cmd_type              cmd,
   output dqp_pkg::stat_type             stat,
   input  dqp_pkg::kind_type             req_kind,
   input  dqp_pkg::pair_type             req_pair,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output dqp_pkg::status_type           rsp_status,
   output dqp_pkg::pair_type             rsp_pair,
   output logic [dqp_pkg::DEPTH_W-1:0]   rsp_depth
);

   dqp_pkg::kind_type                   kind_ff;
   dqp_pkg::pair_type                   key_ff;
   dqp_pkg::pair_type                   cell_ff [dqp_pkg::QUEUE_DEPTH];
   dqp_pkg::pair_type                   cell_in [dqp_pkg::QUEUE_DEPTH];
   logic [dqp_pkg::COUNT_W-1:0]         count_ff;
   logic [dqp_pkg::COUNT_W-1:0]         count_in;
   logic [dqp_pkg::QUEUE_DEPTH-1:0]     match_ff;
   logic [dqp_pkg::QUEUE_DEPTH-1:0]     match_in;
   logic [dqp_pkg::QUEUE_DEPTH-1:0]     upto_match;
   dqp_pkg::status_type                 res_status_ff;
   dqp_pkg::status_type                 res_status_in;
   dqp_pkg::pair_type                   res_pair_ff;
   dqp_pkg::pair_type                   res_pair_in;
   logic                                rsp_valid_ff;
   dqp_pkg::status_type                 rsp_status_ff;
   dqp_pkg::pair_type                   rsp_pair_ff;
   logic [dqp_pkg::DEPTH_W-1:0]         rsp_depth_ff;
   logic                                hit;
   logic                                in_range;
   logic                                full;

   // Compare the key against every occupied cell
   always_comb begin
      for (int j = 0; j < dqp_pkg::QUEUE_DEPTH; j++) begin
         match_in[j] = (cell_ff[j] == key_ff) &&
                       (dqp_pkg::COUNT_W'(j) < count_ff);
      end
   end

   // Mark the matching cell and every cell in front of it
   assign upto_match = match_ff | (match_ff - dqp_pkg::QUEUE_DEPTH'(1));
   assign hit        = |match_ff;
   assign in_range   = (int'(key_ff.chunk) < dqp_pkg::NUM_CHUNKS) &&
                       (int'(key_ff.section) < dqp_pkg::NUM_SECTIONS);
   assign full       = (count_ff >= dqp_pkg::COUNT_W'(dqp_pkg::QUEUE_DEPTH));

   // Work out the next cells, count and status for the captured item
   always_comb begin
      cell_in       = cell_ff;
      count_in      = count_ff;
      res_status_in = dqp_pkg::ST_NOTQ;
      res_pair_in   = '0;
      case (kind_ff)
         dqp_pkg::KIND_PUSH: begin
            if (!in_range) begin
               res_status_in = dqp_pkg::ST_NOTQ;
            end else if (hit) begin
               res_status_in = dqp_pkg::ST_DUP;
            end else if (full) begin
               res_status_in = dqp_pkg::ST_FULL;
            end else begin
               res_status_in = dqp_pkg::ST_QUEUED;
               for (int j = 0; j < dqp_pkg::QUEUE_DEPTH; j++) begin
                  if (dqp_pkg::COUNT_W'(j) == count_ff) begin
                     cell_in[j] = key_ff;
                  end
               end
               count_in = count_ff + dqp_pkg::COUNT_W'(1);
            end
         end
         dqp_pkg::KIND_PROMOTE: begin
            if (in_range && hit) begin
               res_status_in = dqp_pkg::ST_PROMOTED;
               cell_in[0]    = key_ff;
               for (int j = 1; j < dqp_pkg::QUEUE_DEPTH; j++) begin
                  if (upto_match[j]) begin
                     cell_in[j] = cell_ff[j-1];
                  end
               end
            end
         end
         dqp_pkg::KIND_POP: begin
            if (count_ff == '0) begin
               res_status_in = dqp_pkg::ST_EMPTY;
            end else begin
               res_status_in = dqp_pkg::ST_POPPED;
               res_pair_in   = cell_ff[0];
               for (int j = 0; j < dqp_pkg::QUEUE_DEPTH - 1; j++) begin
                  cell_in[j] = cell_ff[j+1];
               end
               count_in = count_ff - dqp_pkg::COUNT_W'(1);
            end
         end
         default: begin
            res_status_in = dqp_pkg::ST_NOTQ;
         end
      endcase
   end

   // Hold the queue count and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.apply) begin
            count_ff <= count_in;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Capture the item, the match row, the update and the result payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_kind;
         key_ff  <= req_pair;
      end
      if (cmd.match) begin
         match_ff <= match_in;
      end
      if (cmd.apply) begin
         cell_ff       <= cell_in;
         res_status_ff <= res_status_in;
         res_pair_ff   <= res_pair_in;
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_pair_ff   <= res_pair_ff;
         rsp_depth_ff  <= dqp_pkg::DEPTH_W'(count_ff);
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_pair      = rsp_pair_ff;
   assign rsp_depth     = rsp_depth_ff;

endmodule

// File: hw/rtl/dedup_queue_with_promote.sv
// Top level of the deduplicating work queue with promote to front.
// An accepted item is captured, compared over the 128-cell chain, used to update
// the chain, then emitted into the result register once that register is free.
// The sequencer runs one item at a time through the compare row and the shift, and
// takes no new item until the last one has been emitted.
// Reset: synchronous, active high; empties the queue at once, no clearing pass.
`include "dedup_queue_with_promote_defines.svh"

module dedup_queue_with_promote (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] chunk_index, [10:8] section_index, rest zero
   input  logic [dqp_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  logic [dqp_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] status, [10:3] out_chunk, [13:11] out_section, [21:14] depth, rest zero
   output logic [dqp_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   dqp_pkg::cmd_type                 cmd;
   dqp_pkg::stat_type                stat;
   dqp_pkg::status_type              rsp_status;
   dqp_pkg::pair_type                rsp_pair;
   logic [dqp_pkg::DEPTH_W-1:0]      rsp_depth;

   dqp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dqp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_kind   (dqp_pkg::kind_type'(req_tuser)),
      .req_pair   (dqp_pkg::pair_type'(req_tdata[dqp_pkg::PAIR_W-1:0])),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_status (rsp_status),
      .rsp_pair   (rsp_pair),
      .rsp_depth  (rsp_depth)
   );

   // Pack the result fields, status lowest
   assign rsp_tdata = {{(dqp_pkg::RSP_TDATA_W - dqp_pkg::RSP_FIELD_W){1'b0}},
                       rsp_depth, rsp_pair, rsp_status};

   `DQP_ASSERT_SAME(a_depth_bound, clock, reset, rsp_tvalid, int'(rsp_depth) <= dqp_pkg::QUEUE_DEPTH)
   `DQP_ASSERT_SAME(a_empty_depth, clock, reset, rsp_tvalid && (rsp_status == dqp_pkg::ST_EMPTY), rsp_depth == '0)
   `DQP_ASSERT_SAME(a_full_depth, clock, reset, rsp_tvalid && (rsp_status == dqp_pkg::ST_FULL), int'(rsp_depth) == dqp_pkg::QUEUE_DEPTH)
   `DQP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)

endmodule
